// ===== src/steering_angle_pid_drive_macros.svh =====
// Assertion macros shared by the steering angle PID drive modules.
// The modules that use them name their clock i_clk and their reset i_rst_n.
`ifndef STEERING_ANGLE_PID_DRIVE_MACROS_SVH
`define STEERING_ANGLE_PID_DRIVE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SAPD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SAPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SAPD_ASSERT_IMPL(label, ante, cons, msg)

`define SAPD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== src/sapd_pkg.sv =====
package sapd_pkg;

    localparam int LO_W     = 8;
    localparam int HI_W     = 8;
    localparam int TGT_W    = 17;
    localparam int ANGLE_W  = 17;
    localparam int ERR_W    = 18;
    localparam int DERIV_W  = 19;
    localparam int SUM_W    = 40;
    localparam int SPLIT_W  = 20;
    localparam int GAIN_W   = 24;
    localparam int TRQ_W    = 16;
    localparam int CTR_W    = 16;
    localparam int DRIVE_W  = 18;
    localparam int ACC_W    = 64;
    localparam int FRAC_W   = 8;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [HI_W-1:0] HIGH_THRESH = 8'd21;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic signed [GAIN_W-1:0] GAIN_PROP_RST  = 24'sd2560;
    localparam logic signed [GAIN_W-1:0] GAIN_INTEG_RST = 24'sd0;
    localparam logic signed [GAIN_W-1:0] GAIN_DERIV_RST = 24'sd0;
    localparam logic signed [TRQ_W-1:0]  TRQ_UPPER_RST  = 16'sd400;
    localparam logic signed [TRQ_W-1:0]  TRQ_LOWER_RST  = -16'sd400;
    localparam logic [CTR_W-1:0]         CENTER_RST     = 16'd3088;

    typedef enum logic [2:0] {
        REG_GAIN_PROP    = 3'd0,
        REG_GAIN_INTEG   = 3'd1,
        REG_GAIN_DERIV   = 3'd2,
        REG_TORQUE_UPPER = 3'd3,
        REG_TORQUE_LOWER = 3'd4,
        REG_DRIVE_CENTER = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_prop;
        logic [GAIN_W-1:0] gain_integ;
        logic [GAIN_W-1:0] gain_deriv;
        logic [TRQ_W-1:0]  torque_upper;
        logic [TRQ_W-1:0]  torque_lower;
        logic [CTR_W-1:0]  drive_center;
    } t_cfg;

    // Terms of one PID step handed from the front end to the multiply stages.
    typedef struct packed {
        logic [ERR_W-1:0]   error;
        logic [ANGLE_W-1:0] angle;
        logic [SUM_W-1:0]   sum;
        logic [DERIV_W-1:0] deriv;
    } t_pid_term;

endpackage

// ===== src/sapd_if.sv =====
interface sapd_in_if;
    import sapd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [LO_W-1:0]          low_byte;
    logic [HI_W-1:0]          high_byte;
    logic signed [TGT_W-1:0]  target_tenths;

    modport source (output valid, low_byte, high_byte, target_tenths, input ready);
    modport sink   (input valid, low_byte, high_byte, target_tenths, output ready);
endinterface

interface sapd_out_if;
    import sapd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [DRIVE_W-1:0]  drive_minus;
    logic signed [DRIVE_W-1:0]  drive_plus;
    logic signed [ERR_W-1:0]    error_tenths;
    logic signed [ANGLE_W-1:0]  angle_tenths;

    modport source (output valid, drive_minus, drive_plus, error_tenths, angle_tenths,
                    input ready);
    modport sink   (input valid, drive_minus, drive_plus, error_tenths, angle_tenths,
                    output ready);
endinterface

// ===== src/sapd_apb_regs.sv =====
module sapd_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sapd_pkg::ADDR_W-1:0]   paddr,
    input  logic [sapd_pkg::DATA_W-1:0]   pwdata,
    output logic [sapd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output sapd_pkg::t_cfg                o_cfg
);
    import sapd_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_prop    <= GAIN_PROP_RST;
            r_cfg.gain_integ   <= GAIN_INTEG_RST;
            r_cfg.gain_deriv   <= GAIN_DERIV_RST;
            r_cfg.torque_upper <= TRQ_UPPER_RST;
            r_cfg.torque_lower <= TRQ_LOWER_RST;
            r_cfg.drive_center <= CENTER_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_GAIN_PROP:    r_cfg.gain_prop    <= pwdata[GAIN_W-1:0];
                REG_GAIN_INTEG:   r_cfg.gain_integ   <= pwdata[GAIN_W-1:0];
                REG_GAIN_DERIV:   r_cfg.gain_deriv   <= pwdata[GAIN_W-1:0];
                REG_TORQUE_UPPER: r_cfg.torque_upper <= pwdata[TRQ_W-1:0];
                REG_TORQUE_LOWER: r_cfg.torque_lower <= pwdata[TRQ_W-1:0];
                REG_DRIVE_CENTER: r_cfg.drive_center <= pwdata[CTR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Signed registers read back sign-extended.
    always_comb begin
        case (w_idx)
            REG_GAIN_PROP:
                prdata = {{(DATA_W-GAIN_W){r_cfg.gain_prop[GAIN_W-1]}}, r_cfg.gain_prop};
            REG_GAIN_INTEG:
                prdata = {{(DATA_W-GAIN_W){r_cfg.gain_integ[GAIN_W-1]}}, r_cfg.gain_integ};
            REG_GAIN_DERIV:
                prdata = {{(DATA_W-GAIN_W){r_cfg.gain_deriv[GAIN_W-1]}}, r_cfg.gain_deriv};
            REG_TORQUE_UPPER:
                prdata = {{(DATA_W-TRQ_W){r_cfg.torque_upper[TRQ_W-1]}}, r_cfg.torque_upper};
            REG_TORQUE_LOWER:
                prdata = {{(DATA_W-TRQ_W){r_cfg.torque_lower[TRQ_W-1]}}, r_cfg.torque_lower};
            REG_DRIVE_CENTER:
                prdata = {{(DATA_W-CTR_W){1'b0}}, r_cfg.drive_center};
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== src/sapd_front.sv =====
`include "steering_angle_pid_drive_macros.svh"

module sapd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sapd_in_if.sink             i_in,
    output logic                o_valid,
    input  logic                i_ready,
    output sapd_pkg::t_pid_term o_term
);
    import sapd_pkg::*;

    typedef struct packed {
        logic [ERR_W-1:0]   error;
        logic [ANGLE_W-1:0] angle;
    } t_meas;

    logic                      r_v0;
    logic                      r_v1;
    logic                      r_v2;
    logic [LO_W-1:0]           r_lo;
    logic [HI_W-1:0]           r_hi;
    logic signed [TGT_W-1:0]   r_target;
    t_meas                     r_s1;
    t_pid_term                 r_s2;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [ERR_W-1:0]   r_prev_error;

    logic                      w_rdy0;
    logic                      w_rdy1;
    logic                      w_rdy2;
    logic                      w_s1_fire;

    logic                      n_pos;
    logic [HI_W-1:0]           n_sel_hi;
    logic [LO_W-1:0]           n_sel_lo;
    logic [ANGLE_W-1:0]        n_mag;
    logic signed [ANGLE_W-1:0] n_angle;
    logic signed [ERR_W-1:0]   n_error;
    logic signed [SUM_W:0]     n_sum_wide;
    logic signed [SUM_W-1:0]   n_sum;
    logic signed [DERIV_W-1:0] n_deriv;

    assign w_rdy2     = !r_v2 || i_ready;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign w_rdy0     = !r_v0 || w_rdy1;
    assign w_s1_fire  = r_v1 && w_rdy2;
    assign i_in.ready = w_rdy0;
    assign o_valid    = r_v2;
    assign o_term     = r_s2;

    // Angle decode. For the positive encoding 255 - x is just ~x on a byte,
    // and both branches share one x*255 = (x << 8) - x.
    always_comb begin
        n_pos    = r_hi > HIGH_THRESH;
        n_sel_hi = n_pos ? ~r_hi : r_hi;
        n_sel_lo = n_pos ? ~r_lo : r_lo;
        n_mag    = {1'b0, n_sel_hi, {LO_W{1'b0}}}
                   - {{(ANGLE_W-HI_W){1'b0}}, n_sel_hi}
                   + {{(ANGLE_W-LO_W){1'b0}}, n_sel_lo};
        n_angle  = n_pos ? $signed(n_mag) : -$signed(n_mag);
        n_error  = {r_target[TGT_W-1], r_target} - {n_angle[ANGLE_W-1], n_angle};
    end

    // Integrator with saturation, and the difference to the previous error.
    always_comb begin
        n_sum_wide = {r_sum[SUM_W-1], r_sum}
                     + {{(SUM_W+1-ERR_W){r_s1.error[ERR_W-1]}}, r_s1.error};
        if (n_sum_wide[SUM_W] != n_sum_wide[SUM_W-1]) begin
            n_sum = n_sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            n_sum = n_sum_wide[SUM_W-1:0];
        end
        n_deriv = {r_s1.error[ERR_W-1], r_s1.error} - {r_prev_error[ERR_W-1], r_prev_error};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0         <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_sum        <= '0;
            r_prev_error <= '0;
        end else begin
            if (w_rdy0) begin
                r_v0 <= i_in.valid;
            end
            if (w_rdy1) begin
                r_v1 <= r_v0;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_s1_fire) begin
                r_sum        <= n_sum;
                r_prev_error <= $signed(r_s1.error);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0 && i_in.valid) begin
            r_lo     <= i_in.low_byte;
            r_hi     <= i_in.high_byte;
            r_target <= i_in.target_tenths;
        end
        if (w_rdy1 && r_v0) begin
            r_s1.error <= n_error;
            r_s1.angle <= n_angle;
        end
        if (w_s1_fire) begin
            r_s2.error <= r_s1.error;
            r_s2.angle <= r_s1.angle;
            r_s2.sum   <= n_sum;
            r_s2.deriv <= n_deriv;
        end
    end

    `SAPD_ASSERT_NEXT(a_prev_error_tracks, w_s1_fire, r_prev_error == $signed($past(r_s1.error)), "previous error does not follow the retired transaction")
    `SAPD_ASSERT_NEXT(a_sum_holds_max, w_s1_fire && r_sum == SUM_MAX && !r_s1.error[ERR_W-1], r_sum == SUM_MAX, "saturated error sum left its upper bound")
    `SAPD_ASSERT_NEXT(a_sum_matches_term, w_s1_fire, r_s2.sum == r_sum, "forwarded error sum differs from the integrator")

endmodule

// ===== src/sapd_mac.sv =====
`include "steering_angle_pid_drive_macros.svh"

module sapd_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sapd_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  sapd_pkg::t_pid_term i_term,
    sapd_out_if.source          o_out
);
    import sapd_pkg::*;

    localparam int PP_W  = GAIN_W + ERR_W;
    localparam int PD_W  = GAIN_W + DERIV_W;
    localparam int PIH_W = GAIN_W + SUM_W - SPLIT_W;
    localparam int PIL_W = GAIN_W + SPLIT_W + 1;
    localparam int TQ_W  = ACC_W - FRAC_W;

    logic                        r_v3;
    logic                        r_v4;
    logic                        r_v5;
    logic signed [PP_W-1:0]      r_pp;
    logic signed [PD_W-1:0]      r_pd;
    logic signed [PIH_W-1:0]     r_pih;
    logic signed [PIL_W-1:0]     r_pil;
    logic [ERR_W-1:0]            r_err3;
    logic [ANGLE_W-1:0]          r_ang3;
    logic signed [ACC_W-1:0]     r_acc;
    logic [ERR_W-1:0]            r_err4;
    logic [ANGLE_W-1:0]          r_ang4;
    logic signed [DRIVE_W-1:0]   r_minus;
    logic signed [DRIVE_W-1:0]   r_plus;
    logic [ERR_W-1:0]            r_err5;
    logic [ANGLE_W-1:0]          r_ang5;

    logic                        w_rdy3;
    logic                        w_rdy4;
    logic                        w_rdy5;

    logic signed [SUM_W-SPLIT_W-1:0] n_sum_hi;
    logic signed [SPLIT_W:0]         n_sum_lo;
    logic signed [ACC_W-1:0]         n_acc;
    logic signed [TQ_W-1:0]          n_torque;
    logic signed [TQ_W-1:0]          n_upper;
    logic signed [TQ_W-1:0]          n_lower;
    logic signed [TRQ_W-1:0]         n_trq;
    logic signed [DRIVE_W-1:0]       n_center;
    logic signed [DRIVE_W-1:0]       n_trq_x;

    assign w_rdy5  = !r_v5 || o_out.ready;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign o_ready = w_rdy3;

    // The 24 x 40 integral product is split into a signed upper half and a
    // zero-extended lower half so no multiplier exceeds 24 x 21.
    assign n_sum_hi = $signed(i_term.sum[SUM_W-1:SPLIT_W]);
    assign n_sum_lo = $signed({1'b0, i_term.sum[SPLIT_W-1:0]});

    always_comb begin
        n_acc = (ACC_W'(r_pih) <<< SPLIT_W) + ACC_W'(r_pil) + ACC_W'(r_pp) + ACC_W'(r_pd);
    end

    // Arithmetic shift drops the fraction, rounding toward minus infinity.
    always_comb begin
        n_torque = r_acc[ACC_W-1:FRAC_W];
        n_upper  = TQ_W'($signed(i_cfg.torque_upper));
        n_lower  = TQ_W'($signed(i_cfg.torque_lower));
        if (n_torque > n_upper) begin
            n_trq = $signed(i_cfg.torque_upper);
        end else if (n_torque < n_lower) begin
            n_trq = $signed(i_cfg.torque_lower);
        end else begin
            n_trq = n_torque[TRQ_W-1:0];
        end
        n_center = $signed({{(DRIVE_W-CTR_W){1'b0}}, i_cfg.drive_center});
        n_trq_x  = {{(DRIVE_W-TRQ_W){n_trq[TRQ_W-1]}}, n_trq};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy3) begin
                r_v3 <= i_valid;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
            if (w_rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && i_valid) begin
            r_pp   <= $signed(i_cfg.gain_prop) * $signed(i_term.error);
            r_pd   <= $signed(i_cfg.gain_deriv) * $signed(i_term.deriv);
            r_pih  <= $signed(i_cfg.gain_integ) * n_sum_hi;
            r_pil  <= $signed(i_cfg.gain_integ) * n_sum_lo;
            r_err3 <= i_term.error;
            r_ang3 <= i_term.angle;
        end
        if (w_rdy4 && r_v3) begin
            r_acc  <= n_acc;
            r_err4 <= r_err3;
            r_ang4 <= r_ang3;
        end
        if (w_rdy5 && r_v4) begin
            r_minus <= n_center - n_trq_x;
            r_plus  <= n_center + n_trq_x;
            r_err5  <= r_err4;
            r_ang5  <= r_ang4;
        end
    end

    assign o_out.valid        = r_v5;
    assign o_out.drive_minus  = r_minus;
    assign o_out.drive_plus   = r_plus;
    assign o_out.error_tenths = $signed(r_err5);
    assign o_out.angle_tenths = $signed(r_ang5);

    `SAPD_ASSERT_NEXT(a_acc_held_on_stall, r_v4 && !w_rdy5, r_v4 && $stable(r_acc), "stalled accumulator stage changed")
    `SAPD_ASSERT_IMPL(a_ready_chain, r_v3 && r_v4 && r_v5 && !o_out.ready, !o_ready, "full pipeline reported space")

endmodule

// ===== src/steering_angle_pid_drive.sv =====
// Steering angle PID drive. Each input transaction carries the two raw bytes
// of the steering angle sensor and a target angle in tenths of a degree; each
// one yields exactly one output transaction with the decoded angle, the error
// (target minus measured), and two differential drive values formed as the
// center value minus and plus the clamped PID torque. The block is a six-deep
// register pipeline that accepts a new transaction in every cycle while the
// output side takes results. When a finished result waits in the output
// register, the block keeps accepting until each of the five stages behind it
// holds a transaction, and then it holds ready low until the result leaves.
// The stages, in order, are the input register, angle decode, integrator
// update, the gain multiplies, the accumulate, and the clamp plus drive
// formation. The running error sum (40-bit, saturating) and the
// previous error are updated as each transaction passes the integrator stage,
// so transactions follow each other with no bubbles. Gains are Q.8 per tenth
// and the weighted sum is shifted right by 8, rounding toward minus infinity;
// the torque is clamped to torque_upper first and then to torque_lower. All
// registers sit on an APB port at byte addresses 0, 4, 8, 12, 16 and 20
// (gain_prop, gain_integ, gain_deriv, torque_upper, torque_lower,
// drive_center). The two low address bits are not decoded; writes to 24 and
// 28 are ignored and reads there return zero.
// Change configuration only while no transaction is in flight.

module steering_angle_pid_drive (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sapd_in_if.sink                       i_in,
    sapd_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sapd_pkg::ADDR_W-1:0]   paddr,
    input  logic [sapd_pkg::DATA_W-1:0]   pwdata,
    output logic [sapd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import sapd_pkg::*;

    t_cfg      w_cfg;
    t_pid_term w_term;
    logic      w_term_valid;
    logic      w_term_ready;

    // Configuration registers and their read-back.
    sapd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sensor decode, error, and the integrator and derivative state.
    sapd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (w_term_valid),
        .i_ready (w_term_ready),
        .o_term  (w_term)
    );

    // Gain multiplies, accumulate, clamp, and the output register.
    sapd_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_term_valid),
        .o_ready (w_term_ready),
        .i_term  (w_term),
        .o_out   (o_out)
    );

endmodule

// ===== tb/tb_steering_angle_pid_drive.sv =====
import sapd_pkg::*;

localparam longint RAW_FULL_SCALE = 255;

// Expected drive values, in the order the block has to deliver them.
typedef struct {
    logic signed [DRIVE_W-1:0] drive_minus;
    logic signed [DRIVE_W-1:0] drive_plus;
    logic signed [ERR_W-1:0]   error_tenths;
    logic signed [ANGLE_W-1:0] angle_tenths;
} t_drive_result;

class pid_drive_tracker;
    longint kp, ki, kd, clamp_hi, clamp_lo, center;
    longint integ, last_err;
    t_drive_result expected_drives[$];
    int mismatches;
    int drives_checked;

    function new();
        kp = longint'(GAIN_PROP_RST);
        ki = longint'(GAIN_INTEG_RST);
        kd = longint'(GAIN_DERIV_RST);
        clamp_hi = longint'(TRQ_UPPER_RST);
        clamp_lo = longint'(TRQ_LOWER_RST);
        center = longint'(CENTER_RST);
        integ = 0;
        last_err = 0;
        mismatches = 0;
        drives_checked = 0;
    endfunction

    function void set_reg(t_reg_idx idx, logic [DATA_W-1:0] val);
        case (idx)
            REG_GAIN_PROP:    kp = longint'($signed(val[GAIN_W-1:0]));
            REG_GAIN_INTEG:   ki = longint'($signed(val[GAIN_W-1:0]));
            REG_GAIN_DERIV:   kd = longint'($signed(val[GAIN_W-1:0]));
            REG_TORQUE_UPPER: clamp_hi = longint'($signed(val[TRQ_W-1:0]));
            REG_TORQUE_LOWER: clamp_lo = longint'($signed(val[TRQ_W-1:0]));
            REG_DRIVE_CENTER: center = longint'(val[CTR_W-1:0]);
            default: ;
        endcase
    endfunction

    // Sensor encoding: a high byte above the threshold means a positive angle sent
    // as complemented bytes, otherwise the angle is negative and sent as is.
    function longint decode_angle(logic [LO_W-1:0] lo, logic [HI_W-1:0] hi);
        longint l, h;
        l = longint'(lo);
        h = longint'(hi);
        if (hi > HIGH_THRESH) begin
            return (RAW_FULL_SCALE - h) * RAW_FULL_SCALE + (RAW_FULL_SCALE - l);
        end
        return -(h * RAW_FULL_SCALE + l);
    endfunction

    function void note_reading(logic [LO_W-1:0] lo, logic [HI_W-1:0] hi,
                               logic signed [TGT_W-1:0] tgt);
        longint angle, err, deriv, acc, trq, dm, dp;
        t_drive_result r;
        angle = decode_angle(lo, hi);
        err = longint'(tgt) - angle;
        integ = integ + err;
        if (integ > longint'(SUM_MAX)) begin
            integ = longint'(SUM_MAX);
        end else if (integ < longint'(SUM_MIN)) begin
            integ = longint'(SUM_MIN);
        end
        deriv = err - last_err;
        last_err = err;
        // The products fit in 64 bits; the arithmetic shift rounds toward minus infinity.
        acc = kp * err + ki * integ + kd * deriv;
        trq = acc >>> FRAC_W;
        if (trq > clamp_hi) begin
            trq = clamp_hi;
        end else if (trq < clamp_lo) begin
            trq = clamp_lo;
        end
        dm = center - trq;
        dp = center + trq;
        r.drive_minus = dm[DRIVE_W-1:0];
        r.drive_plus = dp[DRIVE_W-1:0];
        r.error_tenths = err[ERR_W-1:0];
        r.angle_tenths = angle[ANGLE_W-1:0];
        expected_drives.push_back(r);
    endfunction

    function void check_drive(logic signed [DRIVE_W-1:0] dm, logic signed [DRIVE_W-1:0] dp,
                              logic signed [ERR_W-1:0] err, logic signed [ANGLE_W-1:0] ang);
        t_drive_result e;
        if (expected_drives.size() == 0) begin
            $error("drive result with no reading waiting: drive_minus %0d drive_plus %0d",
                   dm, dp);
            mismatches++;
            return;
        end
        e = expected_drives.pop_front();
        drives_checked++;
        if (dm !== e.drive_minus) begin
            $error("drive_minus: expected %0d, actual %0d", e.drive_minus, dm);
            mismatches++;
        end
        if (dp !== e.drive_plus) begin
            $error("drive_plus: expected %0d, actual %0d", e.drive_plus, dp);
            mismatches++;
        end
        if (err !== e.error_tenths) begin
            $error("error_tenths: expected %0d, actual %0d", e.error_tenths, err);
            mismatches++;
        end
        if (ang !== e.angle_tenths) begin
            $error("angle_tenths: expected %0d, actual %0d", e.angle_tenths, ang);
            mismatches++;
        end
    endfunction

    function int waiting();
        return expected_drives.size();
    endfunction
endclass

module tb_steering_angle_pid_drive;

    // Settling allowance that drain() uses to let the pipeline run empty.
    localparam int PIPE_LAT       = 5;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_READINGS = 150;
    // First register index beyond the mapped ones; writes there must change nothing.
    localparam int FIRST_UNMAPPED = 6;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    sapd_in_if  in_ch();
    sapd_out_if out_ch();

    pid_drive_tracker tracker = new();

    int readings_sent = 0;
    int tunings_applied = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycles = 0;

    steering_angle_pid_drive u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Everything the testbench drives changes on the falling edge, so the block and
    // the monitor below both see settled values at the rising edge.
    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.low_byte = '0;
        in_ch.high_byte = '0;
        in_ch.target_tenths = '0;
        out_ch.ready = 1'b0;
    end

    // The receiver stalls at random; the rate follows the current idling schedule.
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: the result check runs before the new reading is noted. A result can
    // never belong to a reading accepted on the same edge, so the order is safe.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                tracker.check_drive(out_ch.drive_minus, out_ch.drive_plus,
                                    out_ch.error_tenths, out_ch.angle_tenths);
            end
            if (in_ch.valid && in_ch.ready) begin
                tracker.note_reading(in_ch.low_byte, in_ch.high_byte, in_ch.target_tenths);
            end
        end
    end

    // Watchdog, sized far above the slowest legal run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // APB write: setup cycle, then an access cycle that completes when pready is
    // seen. The task is entered on a falling edge and returns on one at which it has
    // not yet assigned anything, so back-to-back calls never double-drive psel.
    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, longint val);
        logic [DATA_W-1:0] data;
        data = val[DATA_W-1:0];
        apb_write({idx, 2'b00}, data);
        tracker.set_reg(idx, data);
    endtask

    task automatic set_tuning(longint p, longint i, longint d, longint up, longint lo,
                              longint ctr);
        write_reg(REG_GAIN_PROP, p);
        write_reg(REG_GAIN_INTEG, i);
        write_reg(REG_GAIN_DERIV, d);
        write_reg(REG_TORQUE_UPPER, up);
        write_reg(REG_TORQUE_LOWER, lo);
        write_reg(REG_DRIVE_CENTER, ctr);
        tunings_applied++;
    endtask

    // Small gains keep the torque inside the clamps often enough to check the
    // rounding; full-range values mostly exercise the clamp and wide products.
    task automatic random_tuning(bit full_range);
        logic [GAIN_W-1:0] gp, gi, gd;
        logic [TRQ_W-1:0]  up, lo;
        longint            ctr;
        gp = GAIN_W'($urandom);
        gi = GAIN_W'($urandom);
        gd = GAIN_W'($urandom);
        up = TRQ_W'($urandom);
        lo = TRQ_W'($urandom);
        ctr = longint'($urandom_range(65535));
        if (full_range) begin
            set_tuning(longint'($signed(gp)), longint'($signed(gi)), longint'($signed(gd)),
                       longint'($signed(up)), longint'($signed(lo)), ctr);
        end else begin
            set_tuning(longint'($urandom_range(8192)) - 4096, longint'($urandom_range(16)) - 8,
                       longint'($urandom_range(4096)) - 2048, longint'($urandom_range(2000)),
                       -longint'($urandom_range(2000)), ctr);
        end
    endtask

    // One reading, with random idle cycles in front of it. Entered and left on a
    // falling edge; valid stays high across back-to-back transactions.
    task automatic send_reading(logic [LO_W-1:0] lo, logic [HI_W-1:0] hi,
                                logic signed [TGT_W-1:0] tgt);
        if (readings_sent < 400) begin
            send_idle_pct = 22;
            recv_idle_pct = 46;
        end else if (readings_sent < 800) begin
            send_idle_pct = 46;
            recv_idle_pct = 22;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.low_byte <= lo;
        in_ch.high_byte <= hi;
        in_ch.target_tenths <= tgt;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        readings_sent++;
    endtask

    // Most targets sit close to the measured angle so that the PID terms stay in
    // the unclamped band; the rest are anywhere in the 17-bit range.
    task automatic send_random_reading();
        logic [LO_W-1:0]         lo;
        logic [HI_W-1:0]         hi;
        logic signed [TGT_W-1:0] tgt;
        longint                  angle, tgt_val;
        int                      mode;
        lo = LO_W'($urandom_range(255));
        hi = HI_W'($urandom_range(255));
        if ($urandom_range(99) < 15) begin
            hi = HI_W'($urandom_range(23, 20));
        end
        angle = tracker.decode_angle(lo, hi);
        mode = $urandom_range(99);
        if (mode < 40) begin
            tgt_val = angle + longint'($urandom_range(200)) - 100;
            tgt = tgt_val[TGT_W-1:0];
        end else if (mode < 60) begin
            tgt_val = angle + longint'($urandom_range(6000)) - 3000;
            tgt = tgt_val[TGT_W-1:0];
        end else begin
            tgt = TGT_W'($urandom_range(131071));
        end
        send_reading(lo, hi, tgt);
    endtask

    // Stops the sender and waits for every outstanding result, then lets the
    // pipeline run empty before the registers may be touched.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (tracker.waiting() != 0) begin
            @(negedge i_clk);
        end
        repeat (PIPE_LAT + 3) @(negedge i_clk);
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed readings under the reset tuning (torque is ten times the error,
        // clamped to plus or minus 400). They cover the byte extremes, both sides of
        // the encoding threshold, the largest errors of either sign, a zero error,
        // and errors right at and just past each clamp.
        send_reading(8'd0, 8'd0, 17'sd0);
        send_reading(8'd255, 8'd0, 17'sd0);
        send_reading(8'd255, 8'd21, -17'sd5610);
        send_reading(8'd0, 8'd21, 17'sd0);
        send_reading(8'd0, 8'd22, 17'sd59670);
        send_reading(8'd255, 8'd22, 17'sd0);
        send_reading(8'd255, 8'd255, 17'sd40);
        send_reading(8'd255, 8'd255, 17'sd41);
        send_reading(8'd255, 8'd255, -17'sd40);
        send_reading(8'd255, 8'd255, -17'sd41);
        send_reading(8'd0, 8'd255, 17'sd255);
        send_reading(8'd128, 8'd128, 17'sd32512);
        send_reading(8'd255, 8'd21, 17'sd65535);
        send_reading(8'd0, 8'd22, 17'h10000);
        send_reading(8'd170, 8'd85, -17'sd1);
        send_reading(8'd85, 8'd170, 17'h0AAAA);
        send_reading(8'd1, 8'd20, 17'h15555);
        send_reading(8'd254, 8'd23, 17'sd3);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                1: set_tuning(8388607, -8388608, 8388607, 32767, -32768, 65535);
                2: set_tuning(-8388608, 8388607, -8388608, 0, 0, 0);
                // Crossed limits: the upper clamp is tested first and wins for any torque above it.
                3: set_tuning(257, -3, -129, -100, 100, 1000);
                5: random_tuning(1'b1);
                6: begin
                    set_tuning(257, -3, -129, 500, -700, 32768);
                    for (int k = 0; k < 2; k++) begin
                        apb_write(ADDR_W'((FIRST_UNMAPPED + k) * 4), $urandom);
                    end
                end
                default: random_tuning(1'b0);
            endcase
            for (int n = 0; n < PHASE_READINGS; n++) begin
                send_random_reading();
            end
            drain();
        end

        $display("Covered %0d sensor readings under %0d register settings; %0d drive results",
                 readings_sent, tunings_applied, tracker.drives_checked);
        $display("were checked field by field, with idling on either side and none at all.");
        if (tracker.mismatches == 0 && tracker.waiting() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
